// ===== src/lspe_pkg.sv =====
// Shared types and constants for the LSB stego payload extractor.
// No dependencies; imported by lspe_decoder and lsb_stego_payload_extractor.
package lspe_pkg;

    localparam int MAGIC_MAX_BYTES_DEF = 8;
    localparam logic [15:0] HDR_OFFSET_RST = 16'd54;
    localparam logic [3:0]  MAGIC_LEN_RST  = 4'd2;

    localparam int CNT_W = 32;
    localparam int LEN_W = 32;
    localparam int POS_W = 5;

    typedef enum logic [1:0] {
        CFG_HDR_OFFSET = 2'd0,
        CFG_MAGIC_LEN  = 2'd1,
        CFG_MAGIC_WORD = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXT     = 3'd3,
        PH_PAYLEN  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_EXT       = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_MAGIC_ERR = 2'd2,
        KIND_EMPTY     = 2'd3
    } t_kind;

    typedef struct packed {
        logic [15:0] hdr_offset;
        logic [3:0]  magic_len;
    } t_cfg;

endpackage

// ===== src/lspe_decoder.sv =====
// Field decoder: walks header, magic, lengths, extension and payload one beat
// per cycle unless a held result stalls it, and holds the result register. Depends on lspe_pkg.
module lspe_decoder import lspe_pkg::*; #(
    parameter int MAGIC_MAX_BYTES = MAGIC_MAX_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic [8*MAGIC_MAX_BYTES-1:0] i_magic_word,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_start,
    input  logic                         i_bit,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output t_kind                        o_kind,
    output logic [7:0]                   o_value,
    output logic                         o_last
);

    localparam int IDX_W = (MAGIC_MAX_BYTES > 1) ? $clog2(MAGIC_MAX_BYTES) : 1;
    localparam logic [3:0] MLEN_MAX = 4'(MAGIC_MAX_BYTES);

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [LEN_W-1:0]  r_acc, n_acc;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_ok, n_ok;
    logic              r_out_valid;
    t_kind             r_kind;
    logic [7:0]        r_value;
    logic              r_last;

    logic              step;
    logic              res_valid;
    t_kind             res_kind;
    logic [7:0]        res_value;
    logic              res_last;
    logic [3:0]        mle;
    logic [7:0]        magic_bytes [MAGIC_MAX_BYTES];

    assign o_ready = !r_out_valid || i_out_ready;
    assign step    = i_valid && o_ready;
    assign mle     = (i_cfg.magic_len > MLEN_MAX) ? MLEN_MAX : i_cfg.magic_len;

    always_comb begin
        for (int k = 0; k < MAGIC_MAX_BYTES; k++) begin
            magic_bytes[k] = i_magic_word[8*k +: 8];
        end
    end

    always_comb begin
        logic             go;
        logic [7:0]       ch;
        logic [IDX_W-1:0] idx;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_len     = r_len;
        n_ok      = r_ok;
        res_valid = 1'b0;
        res_kind  = KIND_EXT;
        res_value = 8'd0;
        res_last  = 1'b0;
        go        = 1'b0;
        ch        = 8'd0;
        idx       = '0;
        if (step) begin
            go = 1'b1;
            if (i_start) begin
                n_phase = PH_HEADER;
                n_cnt   = '0;
                n_pos   = '0;
                n_acc   = '0;
                n_ok    = 1'b1;
            end
            if (n_phase == PH_HEADER) begin
                if (n_cnt < {16'd0, i_cfg.hdr_offset}) begin
                    n_cnt = n_cnt + 1'b1;
                    go    = 1'b0;
                end else begin
                    n_phase = PH_MAGIC;
                    n_cnt   = '0;
                    n_pos   = '0;
                    n_acc   = '0;
                end
            end
            // magic already complete (zero or lowered length)
            if (go && n_phase == PH_MAGIC && n_cnt >= {28'd0, mle}) begin
                n_cnt = '0;
                n_pos = '0;
                n_acc = '0;
                if (!n_ok) begin
                    n_phase   = PH_DONE;
                    res_valid = 1'b1;
                    res_kind  = KIND_MAGIC_ERR;
                    go        = 1'b0;
                end else begin
                    n_phase = PH_EXTLEN;
                    // lowered length: this beat carries no bit
                    if (mle != 4'd0) go = 1'b0;
                end
            end
            if (n_phase == PH_DONE) go = 1'b0;
            if (go) begin
                n_acc = n_acc | ({{(LEN_W-1){1'b0}}, i_bit} << n_pos);
                if (n_phase == PH_EXTLEN || n_phase == PH_PAYLEN) begin
                    if (n_pos != 5'd31) begin
                        n_pos = n_pos + 1'b1;
                    end else begin
                        n_len = n_acc;
                        n_cnt = '0;
                        n_pos = '0;
                        n_acc = '0;
                        if (n_phase == PH_EXTLEN) begin
                            n_phase = (n_len != '0) ? PH_EXT : PH_PAYLEN;
                        end else if (n_len == '0) begin
                            n_phase   = PH_DONE;
                            res_valid = 1'b1;
                            res_kind  = KIND_EMPTY;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end else if (n_pos != 5'd7) begin
                    n_pos = n_pos + 1'b1;
                end else begin
                    ch    = n_acc[7:0];
                    idx   = n_cnt[IDX_W-1:0];
                    n_pos = '0;
                    n_acc = '0;
                    n_cnt = n_cnt + 1'b1;
                    case (n_phase)
                        PH_MAGIC: begin
                            if (ch != magic_bytes[idx]) n_ok = 1'b0;
                            if (n_cnt >= {28'd0, mle}) begin
                                n_cnt = '0;
                                if (!n_ok) begin
                                    n_phase   = PH_DONE;
                                    res_valid = 1'b1;
                                    res_kind  = KIND_MAGIC_ERR;
                                end else begin
                                    n_phase = PH_EXTLEN;
                                end
                            end
                        end
                        PH_EXT: begin
                            res_valid = 1'b1;
                            res_kind  = KIND_EXT;
                            res_value = ch;
                            if (n_cnt >= n_len) begin
                                n_phase = PH_PAYLEN;
                                n_cnt   = '0;
                            end
                        end
                        default: begin
                            res_valid = 1'b1;
                            res_kind  = KIND_PAYLOAD;
                            res_value = ch;
                            if (n_cnt >= n_len) begin
                                n_phase  = PH_DONE;
                                n_cnt    = '0;
                                res_last = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_acc       <= '0;
            r_len       <= '0;
            r_ok        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_len   <= n_len;
            r_ok    <= n_ok;
            if (o_ready) r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_kind  <= res_kind;
            r_value <= res_value;
            r_last  <= res_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_MAGIC_ERR || r_kind == KIND_EMPTY)
        |-> !r_last && r_value == 8'd0)
        else $error("error or end marker carries data");

    a_stop_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && res_valid && (res_kind == KIND_MAGIC_ERR || res_last)
        |=> r_phase == PH_DONE)
        else $error("decode did not stop after terminal result");

    a_byte_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MAGIC || r_phase == PH_EXT || r_phase == PH_PAYLOAD)
        |-> r_pos <= 5'd7)
        else $error("bit position past byte in byte field");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && !i_start && r_phase == PH_DONE |-> !res_valid)
        else $error("result after end of decode");

endmodule

// ===== src/lsb_stego_payload_extractor.sv =====
// Top level of the LSB stego payload extractor: config registers, input beat
// register and the field decoder. Depends on lspe_pkg and lspe_decoder.
//
//  channel  | dir | handshake                    | content
//  ---------+-----+------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: image_byte, tuser: image_start
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: result_value, tuser: kind,
//           |     |                              | tlast: last_byte
//  cfg      | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One image byte per cycle sustained while m_axis_tready is high. The per-byte
// decode step is a single pass through the decoder between the input register
// and the result register. Synchronous active-low reset returns to a fresh
// image with default config. m_axis_tready low holds the result; the input
// register takes one more beat only if it is empty, then s_axis_tready drops.
module lsb_stego_payload_extractor import lspe_pkg::*; #(
    parameter int MAGIC_MAX_BYTES = MAGIC_MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] image_byte
    input  logic        s_axis_tuser,   // [0] image_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] result_value
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int MW_W = 8 * MAGIC_MAX_BYTES;

    t_cfg            r_cfg;
    logic [MW_W-1:0] r_magic;
    logic            r_in_valid;
    logic            r_in_start;
    logic            r_in_bit;
    logic            dec_ready;
    t_kind           out_kind;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_offset <= HDR_OFFSET_RST;
            r_cfg.magic_len  <= MAGIC_LEN_RST;
            r_magic          <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HDR_OFFSET: r_cfg.hdr_offset <= i_cfg_data[15:0];
                CFG_MAGIC_LEN:  r_cfg.magic_len  <= i_cfg_data[3:0];
                CFG_MAGIC_WORD: r_magic          <= i_cfg_data[MW_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_in_valid || dec_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_start <= s_axis_tuser;
            r_in_bit   <= s_axis_tdata[0];
        end
    end

    lspe_decoder #(
        .MAGIC_MAX_BYTES (MAGIC_MAX_BYTES)
    ) u_dec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_magic_word (r_magic),
        .i_valid      (r_in_valid),
        .o_ready      (dec_ready),
        .i_start      (r_in_start),
        .i_bit        (r_in_bit),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_kind       (out_kind),
        .o_value      (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;

endmodule

// ===== tb/tb_lsb_stego_payload_extractor.sv =====
`timescale 1ns / 100ps
// Testbench for lsb_stego_payload_extractor: streams stego images with hidden fields
// in the byte LSBs and checks every output beat against an in-bench decoder model.
// Depends on lspe_pkg and the lsb_stego_payload_extractor RTL.
module tb_lsb_stego_payload_extractor import lspe_pkg::*;;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_SHOWN      = 10;
    localparam int EXT_CHARS_CAP  = 6;
    localparam int PAY_BYTES_CAP  = 8;

    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_decoded;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    lsb_stego_payload_extractor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // decoder model: register copies and decode state
    logic [15:0] cfg_hdr;
    logic [3:0]  cfg_mlen;
    logic [63:0] cfg_word;
    t_phase      ph;
    logic [31:0] ph_cnt;
    logic [4:0]  bpos;
    logic [31:0] acc;
    logic [31:0] ext_len;
    logic [31:0] pay_len;
    bit          magic_good;

    t_decoded    pending_results[$];
    logic [7:0]  image_q[$];
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned idle_cycles;
    int          src_gap_max;
    int          src_burst;
    int          sink_burst;

    function automatic int draw_wait(inout int burst, input int max_gap);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, max_gap);
    endfunction

    function automatic int unsigned magic_count();
        return (cfg_mlen > MAGIC_MAX_BYTES_DEF) ? MAGIC_MAX_BYTES_DEF : cfg_mlen;
    endfunction

    function automatic void enter_phase(t_phase p);
        ph     = p;
        ph_cnt = '0;
        bpos   = '0;
        acc    = '0;
    endfunction

    function automatic void restart_image();
        enter_phase(PH_HEADER);
        ext_len    = '0;
        pay_len    = '0;
        magic_good = 1'b1;
    endfunction

    // One image byte through the decoder; returns 1 when it yields an output beat.
    function automatic bit decode_step(input bit start, input logic [7:0] data,
                                       output t_decoded res);
        int unsigned mlen;
        logic [7:0]  ch;
        logic [2:0]  idx;
        res.kind  = KIND_EXT;
        res.value = '0;
        res.last  = 1'b0;
        mlen = magic_count();
        if (start)
            restart_image();
        if (ph == PH_HEADER) begin
            if (ph_cnt < cfg_hdr) begin
                ph_cnt++;
                return 0;
            end
            enter_phase(PH_MAGIC);
        end
        if (ph == PH_MAGIC && ph_cnt >= mlen) begin
            if (!magic_good) begin
                enter_phase(PH_DONE);
                res.kind = KIND_MAGIC_ERR;
                return 1;
            end
            enter_phase(PH_EXTLEN);
            // magic concluded by a lowered length: this byte carries no bit
            if (mlen != 0)
                return 0;
        end
        if (ph == PH_DONE)
            return 0;
        if (data[0])
            acc[bpos] = 1'b1;
        if (ph == PH_EXTLEN || ph == PH_PAYLEN) begin
            if (bpos < 5'd31) begin
                bpos++;
                return 0;
            end
            if (ph == PH_EXTLEN) begin
                ext_len = acc;
                enter_phase(acc != 0 ? PH_EXT : PH_PAYLEN);
                return 0;
            end
            pay_len = acc;
            if (acc == 0) begin
                enter_phase(PH_DONE);
                res.kind = KIND_EMPTY;
                return 1;
            end
            enter_phase(PH_PAYLOAD);
            return 0;
        end
        if (bpos < 5'd7) begin
            bpos++;
            return 0;
        end
        ch   = acc[7:0];
        bpos = '0;
        acc  = '0;
        ph_cnt++;
        if (ph == PH_MAGIC) begin
            idx = 3'(ph_cnt - 1);
            if (ch != cfg_word[8*idx +: 8])
                magic_good = 1'b0;
            if (ph_cnt >= mlen) begin
                if (!magic_good) begin
                    enter_phase(PH_DONE);
                    res.kind = KIND_MAGIC_ERR;
                    return 1;
                end
                enter_phase(PH_EXTLEN);
            end
            return 0;
        end
        res.value = ch;
        if (ph == PH_EXT) begin
            if (ph_cnt >= ext_len)
                enter_phase(PH_PAYLEN);
            return 1;
        end
        res.kind = KIND_PAYLOAD;
        if (ph_cnt >= pay_len) begin
            enter_phase(PH_DONE);
            res.last = 1'b1;
        end
        return 1;
    endfunction

    // ---------------- image construction ----------------
    function automatic void push_bits(input logic [31:0] val, input int n);
        for (int i = 0; i < n; i++)
            image_q.push_back({7'($urandom), val[i]});
    endfunction

    function automatic void push_noise(input int n);
        for (int i = 0; i < n; i++)
            image_q.push_back(8'($urandom));
    endfunction

    function automatic void build_image(input bit bad_magic, input logic [31:0] ext_n,
                                        input logic [31:0] pay_n);
        int unsigned mlen;
        int unsigned bad_idx;
        logic [7:0]  mbyte;
        image_q.delete();
        mlen    = magic_count();
        bad_idx = (mlen != 0) ? $urandom_range(0, mlen - 1) : 0;
        push_noise(cfg_hdr);
        for (int i = 0; i < mlen; i++) begin
            mbyte = cfg_word[8*i +: 8];
            if (bad_magic && i == bad_idx)
                mbyte[$urandom_range(0, 7)] ^= 1'b1;
            push_bits(mbyte, 8);
        end
        push_bits(ext_n, 32);
        for (int i = 0; i < EXT_CHARS_CAP && i < ext_n; i++)
            push_bits($urandom, 8);
        if (ext_n > EXT_CHARS_CAP)
            return;
        push_bits(pay_n, 32);
        for (int i = 0; i < PAY_BYTES_CAP && i < pay_n; i++)
            push_bits($urandom, 8);
    endfunction

    // ---------------- stimulus drivers ----------------
    task automatic send_byte(input bit start, input logic [7:0] data);
        int       gap;
        t_decoded res;
        gap = draw_wait(src_burst, src_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (decode_step(start, data, res))
            pending_results.push_back(res);
    endtask

    task automatic send_image(input bit with_start, input int unsigned first,
                              input int unsigned count);
        for (int unsigned i = first; i < count && i < image_q.size(); i++)
            send_byte(with_start && i == first, image_q[i]);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data, input bit hold);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HDR_OFFSET: cfg_hdr = data[15:0];
            CFG_MAGIC_LEN:  cfg_mlen = data[3:0];
            default:        cfg_word = data;
        endcase
        if (!hold)
            i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [63:0] hdr, input logic [63:0] mlen,
                            input logic [63:0] word);
        write_reg(CFG_HDR_OFFSET, hdr, 1'b1);
        write_reg(CFG_MAGIC_LEN, mlen, 1'b1);
        write_reg(CFG_MAGIC_WORD, word, 1'b0);
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        // no image start after reset: first byte is byte zero
        build_image(1'b0, 32'd2, 32'd3);
        push_noise(3);
        send_image(1'b0, 0, image_q.size());
    endtask

    task automatic test_no_header_no_magic();
        wait_idle();
        set_regs(64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        build_image(1'b0, 32'd0, 32'd0);
        push_noise(4);
        send_image(1'b1, 0, image_q.size());
        build_image(1'b0, 32'd0, 32'd1);
        send_image(1'b1, 0, image_q.size());
    endtask

    task automatic test_magic_mismatch();
        wait_idle();
        set_regs(64'd3, 64'd3, {$urandom, $urandom});
        build_image(1'b1, 32'd1, 32'd2);
        push_noise(6);
        send_image(1'b1, 0, image_q.size());
    endtask

    task automatic test_magic_saturation();
        wait_idle();
        set_regs(64'd1, 64'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        build_image(1'b0, 32'd1, 32'd2);
        send_image(1'b1, 0, image_q.size());
        wait_idle();
        set_regs(64'd2, 64'd9, 64'd0);
        build_image(1'b0, 32'd0, 32'd1);
        send_image(1'b1, 0, image_q.size());
    endtask

    task automatic test_config_mid_field();
        logic [63:0] word;
        word = {$urandom, $urandom};
        // magic length lowered to the count already decoded, match then mismatch
        wait_idle();
        set_regs(64'd1, 64'd4, word);
        build_image(1'b0, 32'd1, 32'd1);
        send_image(1'b1, 0, 1 + 19);
        wait_idle();
        write_reg(CFG_MAGIC_LEN, 64'd2, 1'b0);
        send_byte(1'b0, 8'($urandom));
        build_image(1'b0, 32'd1, 32'd1);
        send_image(1'b0, 1 + 16, image_q.size());
        wait_idle();
        write_reg(CFG_MAGIC_LEN, 64'd4, 1'b0);
        image_q.delete();
        push_noise(1);
        push_bits(~word[7:0], 8);
        push_bits(word[15:8], 8);
        push_bits(32'd0, 3);
        send_image(1'b1, 0, image_q.size());
        wait_idle();
        write_reg(CFG_MAGIC_LEN, 64'd2, 1'b0);
        send_byte(1'b0, 8'($urandom));
        push_noise(3);
        // header offset lowered part way through the header
        wait_idle();
        set_regs(64'd10, 64'd1, word);
        image_q.delete();
        push_noise(5);
        send_image(1'b1, 0, image_q.size());
        wait_idle();
        write_reg(CFG_HDR_OFFSET, 64'd2, 1'b0);
        build_image(1'b0, 32'd1, 32'd2);
        send_image(1'b0, 2, image_q.size());
    endtask

    task automatic test_max_header();
        wait_idle();
        set_regs(64'hFFFF, 64'd1, 64'h0000_0000_0000_00A5);
        src_gap_max = 0;
        image_q.delete();
        push_noise(40);
        send_image(1'b1, 0, image_q.size());
        // drop the offset to the bytes already skipped, then finish the image
        wait_idle();
        write_reg(CFG_HDR_OFFSET, 64'd40, 1'b0);
        build_image(1'b0, 32'd1, 32'd1);
        send_image(1'b0, 40, image_q.size());
        src_gap_max = 19;
    endtask

    task automatic test_huge_lengths();
        wait_idle();
        set_regs(64'd0, 64'd1, 64'h5A);
        build_image(1'b0, 32'hFFFF_FFFF, 32'd0);
        send_image(1'b1, 0, image_q.size());
        build_image(1'b0, 32'd0, 32'hFFFF_FFFF);
        send_image(1'b1, 0, image_q.size());
        build_image(1'b0, 32'd2, 32'd2);
        send_image(1'b1, 0, image_q.size());
    endtask

    task automatic test_random_images();
        int unsigned goal;
        int unsigned n_img;
        int unsigned mode;
        int unsigned keep;
        logic [31:0] ext_n;
        logic [31:0] pay_n;
        logic [15:0] hdr;
        logic [3:0]  mlen;
        goal  = items_sent + 300;
        n_img = 0;
        while (items_sent < goal) begin
            if (n_img % 4 == 0) begin
                wait_idle();
                hdr  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(9, 40))
                                                   : 16'($urandom_range(0, 6));
                mlen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 3));
                set_regs({$urandom, 16'($urandom), hdr}, {$urandom, 28'($urandom), mlen},
                         {$urandom, $urandom});
            end else if ($urandom_range(0, 5) == 0) begin
                wait_idle();
            end
            mode  = $urandom_range(0, 9);
            ext_n = $urandom_range(0, 3);
            pay_n = $urandom_range(0, 8);
            case (mode)
                0: begin
                    image_q.delete();
                    push_noise($urandom_range(4, 40));
                end
                1: build_image(1'b1, ext_n, pay_n);
                2: build_image(1'b0, $urandom, pay_n);
                3: build_image(1'b0, ext_n, $urandom);
                default: build_image(1'b0, ext_n, pay_n);
            endcase
            push_noise($urandom_range(0, 4));
            keep = image_q.size();
            if (mode == 4)
                keep = $urandom_range(1, keep);
            send_image($urandom_range(0, 15) != 0, 0, keep);
            n_img++;
        end
    endtask

    // ---------------- output side ----------------
    function automatic void check_beat(input logic [7:0] value, input logic [1:0] kind,
                                       input logic last);
        t_decoded want;
        results_seen++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("[%0t] unexpected beat: kind=%0d value=%02h last=%0d",
                         $realtime, kind, value, last);
            return;
        end
        want = pending_results.pop_front();
        if (kind !== want.kind || value !== want.value || last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("[%0t] beat %0d: exp kind=%0d value=%02h last=%0d,",
                         $realtime, results_seen, want.kind, want.value, want.last,
                         " got kind=%0d value=%02h last=%0d", kind, value, last);
        end
    endfunction

    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait(sink_burst, 19);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_HDR_OFFSET;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        idle_cycles   = 0;
        items_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        src_gap_max   = 19;
        src_burst     = 0;
        sink_burst    = 0;
        cfg_hdr       = HDR_OFFSET_RST;
        cfg_mlen      = MAGIC_LEN_RST;
        cfg_word      = '0;
        restart_image();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_no_header_no_magic();
        test_magic_mismatch();
        test_magic_saturation();
        test_config_mid_field();
        test_huge_lengths();
        test_max_header();
        test_random_images();

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
